>>> design/mqcs_pkg.sv
// shared types, constants and selection rules of the multi-queue scheduler
`default_nettype none

package mqcs_pkg;

  localparam int unsigned NUM_SERVERS = 5;
  localparam int unsigned NUM_CLASSES = 3;
  localparam int unsigned SRV_W       = 3;
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned RES_DEPTH   = 16;
  localparam int unsigned RES_AW      = 4;
  localparam int unsigned CFG_AW      = 1;
  localparam int unsigned CFG_DW      = 16;

  localparam logic [CFG_AW-1:0] CFG_MODE    = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_PROMOTE = 1'b1;

  localparam logic [1:0] Q_FIRST    = 2'd0;
  localparam logic [1:0] Q_BUSINESS = 2'd1;
  localparam logic [1:0] Q_ECONOMY  = 2'd2;

  typedef enum logic [1:0] {
    MODE_FCFS   = 2'd0,
    MODE_CLASS  = 2'd1,
    MODE_SJF    = 2'd2,
    MODE_MIXED  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    K_ACCEPTED  = 3'd0,
    K_DROPPED   = 3'd1,
    K_STARTED   = 3'd2,
    K_COMPLETED = 3'd3,
    K_TICK_END  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    C_FIRST = 2'd0,
    C_AGE   = 2'd1,
    C_SPN   = 2'd2,
    C_HRRN  = 2'd3
  } crit_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARR,
    S_AG_RD,
    S_AG_DO,
    S_SRV,
    S_PASS,
    S_MUL,
    S_CMP,
    S_PICK,
    S_CNT,
    S_END
  } st_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arr;
    logic [9:0]  svc;
    logic        promo;
  } job_t;

  typedef struct packed {
    logic        tick;
    logic [1:0]  qsel;
    logic [15:0] id;
    logic [9:0]  svc;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [SRV_W-1:0]  server;
    logic [15:0]       job_ident;
    logic [15:0]       event_time;
    logic [15:0]       turnaround;
    logic [15:0]       waiting;
    logic              promoted;
    logic              last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] q;
    crit_e      crit;
    logic       heads;
    logic       stop;
  } plan_t;

  function automatic plan_t plan_of(mode_e mode, logic [SRV_W-1:0] srv, logic [1:0] pass);
    plan_t p;
    p = '{valid: 1'b0, q: Q_FIRST, crit: C_FIRST, heads: 1'b0, stop: 1'b0};
    unique case (mode)
      MODE_FCFS: begin
        p.valid = (pass != 2'd3);
        p.q     = pass;
        p.crit  = C_AGE;
        p.heads = 1'b1;
      end
      MODE_CLASS: begin
        p.valid = (pass != 2'd3);
        p.q     = pass;
        p.crit  = C_FIRST;
        p.heads = 1'b1;
      end
      MODE_SJF: begin
        p.valid = (pass != 2'd3);
        p.q     = pass;
        p.crit  = C_SPN;
      end
      MODE_MIXED: begin
        priority case (srv)
          3'd0: begin
            p.valid = (pass == 2'd0);
            p.q     = Q_FIRST;
            p.crit  = C_FIRST;
            p.heads = 1'b1;
          end
          3'd1: begin
            p.valid = (pass == 2'd0);
            p.q     = Q_BUSINESS;
            p.crit  = C_HRRN;
          end
          3'd2: begin
            p.valid = (pass == 2'd0);
            p.q     = Q_ECONOMY;
            p.crit  = C_SPN;
          end
          3'd3: begin
            p.valid = (pass == 2'd0) || (pass == 2'd1);
            p.q     = (pass == 2'd0) ? Q_ECONOMY : Q_BUSINESS;
            p.crit  = (pass == 2'd0) ? C_SPN : C_HRRN;
            p.stop  = (pass == 2'd0);
          end
          default: begin
            p.valid = (pass == 2'd0) || (pass == 2'd1);
            p.q     = (pass == 2'd0) ? Q_BUSINESS : Q_ECONOMY;
            p.crit  = (pass == 2'd0) ? C_HRRN : C_SPN;
            p.stop  = (pass == 2'd0);
          end
        endcase
      end
      default: p.valid = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/mqcs_front.sv
// front end: takes input transactions, classifies them and queues them for the engine
`default_nettype none

module mqcs_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic         command_i,
  input  wire logic [15:0]  job_id_i,
  input  wire logic [1:0]   grade_i,
  input  wire logic [9:0]   service_time_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_pop_i,
  output mqcs_pkg::cmd_t    cmd_o
);
  import mqcs_pkg::*;

  localparam int unsigned PW = $clog2(CMD_DEPTH);

  cmd_t          buf_q [CMD_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  cmd_t          cls;
  logic          wr_en, rd_en;

  always_comb begin
    cls.tick = command_i;
    cls.id   = job_id_i;
    cls.svc  = (service_time_i == 10'd0) ? 10'd1 : service_time_i;
    priority if (grade_i == 2'd1) cls.qsel = Q_FIRST;
    else if (grade_i == 2'd2)     cls.qsel = Q_BUSINESS;
    else                          cls.qsel = Q_ECONOMY;
  end

  assign full        = (cnt_q == (PW+1)'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = buf_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

>>> design/mqcs_rfifo.sv
// result queue between the engine and the result ports
`default_nettype none

module mqcs_rfifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire mqcs_pkg::res_t wr_data_i,
  output logic                full_o,
  output logic                empty_o,
  input  wire logic           rd_en_i,
  output mqcs_pkg::res_t      rd_data_o
);
  import mqcs_pkg::*;

  res_t              mem_q [RES_DEPTH];
  logic [RES_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [RES_AW:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == (RES_AW+1)'(RES_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_d  = do_wr ? wr_q + 1'b1 : wr_q;
    rd_d  = do_rd ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (RES_AW+1)'(do_wr) - (RES_AW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/mqcs_engine.sv
// back end: class queues, servers, aging, selection scan and countdown
`default_nettype none

module mqcs_engine #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     mode_i,
  input  wire logic [15:0]    promote_after_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  input  wire mqcs_pkg::cmd_t cmd_i,
  output logic                res_push_o,
  input  wire logic           res_full_i,
  output mqcs_pkg::res_t      res_o
);
  import mqcs_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  st_e               st_q, st_d;
  job_t              mem_q [NUM_CLASSES][QUEUE_DEPTH];
  logic [CW-1:0]     cnt_q [NUM_CLASSES];
  logic [CW-1:0]     cnt_d [NUM_CLASSES];
  logic              busy_q [NUM_SERVERS];
  logic              busy_d [NUM_SERVERS];
  logic [9:0]        rem_q [NUM_SERVERS];
  logic [9:0]        rem_d [NUM_SERVERS];
  job_t              sjob_q [NUM_SERVERS];
  job_t              sjob_d [NUM_SERVERS];
  logic [15:0]       now_q, now_d;
  cmd_t              cmd_q, cmd_d;
  logic [SRV_W-1:0]  srv_q, srv_d;
  logic [1:0]        pass_q, pass_d;
  logic [CW-1:0]     idx_q, idx_d;
  job_t              cand_q;
  job_t              best_q, best_d;
  logic              bvalid_q, bvalid_d;
  logic [1:0]        bq_q, bq_d;
  logic [CW-1:0]     bidx_q, bidx_d;
  logic [15:0]       cage_q, cage_d, bage_q, bage_d;
  logic [26:0]       lhs_q, lhs_d, rhs_q, rhs_d;

  logic              rd_en;
  logic [1:0]        rd_sel;
  logic [CW-1:0]     rd_idx;
  logic              take_en, push_en;
  logic [1:0]        take_sel, push_sel;
  logic [CW-1:0]     take_idx;
  job_t              push_job;
  plan_t             pl;
  logic [CW-1:0]     limit;
  logic [15:0]       ag_age, done_t, ta;
  logic              better;

  assign pl = plan_of(mode_e'(mode_i), srv_q, pass_q);

  always_comb begin
    ag_age = now_q - cand_q.arr;
    done_t = now_q + 16'd1;
    ta     = done_t - sjob_q[srv_q].arr;
    if (pl.heads) begin
      limit = (cnt_q[pl.q] != '0) ? CW'(1) : '0;
    end else begin
      limit = cnt_q[pl.q];
    end
    unique case (pl.crit)
      C_AGE:   better = cage_q > bage_q;
      C_SPN:   better = (cand_q.svc < best_q.svc) ||
                        ((cand_q.svc == best_q.svc) && (cage_q > bage_q));
      C_HRRN:  better = lhs_q > rhs_q;
      default: better = 1'b0;
    endcase
  end

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    rem_d     = rem_q;
    sjob_d    = sjob_q;
    now_d     = now_q;
    cmd_d     = cmd_q;
    srv_d     = srv_q;
    pass_d    = pass_q;
    idx_d     = idx_q;
    best_d    = best_q;
    bvalid_d  = bvalid_q;
    bq_d      = bq_q;
    bidx_d    = bidx_q;
    cage_d    = cage_q;
    bage_d    = bage_q;
    lhs_d     = lhs_q;
    rhs_d     = rhs_q;
    rd_en     = 1'b0;
    rd_sel    = Q_ECONOMY;
    rd_idx    = idx_q;
    take_en   = 1'b0;
    take_sel  = Q_ECONOMY;
    take_idx  = idx_q;
    push_en   = 1'b0;
    push_sel  = cmd_q.qsel;
    push_job  = '{id: cmd_q.id, arr: now_q, svc: cmd_q.svc, promo: 1'b0};
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o     = '{kind: K_TICK_END, server: '0, job_ident: '0, event_time: now_q,
                  turnaround: '0, waiting: '0, promoted: 1'b0, last: 1'b0};

    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          srv_d     = '0;
          if (!cmd_i.tick) begin
            st_d = S_ARR;
          end else if (mode_e'(mode_i) == MODE_MIXED) begin
            st_d = S_AG_RD;
          end else begin
            st_d = S_SRV;
          end
        end
      end
      S_ARR: begin
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.job_ident  = cmd_q.id;
          res_o.last       = 1'b1;
          if (cnt_q[cmd_q.qsel] < CW'(QUEUE_DEPTH)) begin
            push_en              = 1'b1;
            cnt_d[cmd_q.qsel]    = cnt_q[cmd_q.qsel] + 1'b1;
            res_o.kind           = K_ACCEPTED;
          end else begin
            res_o.kind = K_DROPPED;
          end
          st_d = S_IDLE;
        end
      end
      S_AG_RD: begin
        if (idx_q < cnt_q[Q_ECONOMY]) begin
          rd_en  = 1'b1;
          rd_sel = Q_ECONOMY;
          st_d   = S_AG_DO;
        end else begin
          st_d = S_SRV;
        end
      end
      S_AG_DO: begin
        if ((ag_age > promote_after_i) && !cand_q.promo &&
            (cnt_q[Q_BUSINESS] < CW'(QUEUE_DEPTH))) begin
          take_en            = 1'b1;
          take_sel           = Q_ECONOMY;
          push_en            = 1'b1;
          push_sel           = Q_BUSINESS;
          push_job           = cand_q;
          push_job.promo     = 1'b1;
          cnt_d[Q_ECONOMY]   = cnt_q[Q_ECONOMY] - 1'b1;
          cnt_d[Q_BUSINESS]  = cnt_q[Q_BUSINESS] + 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
        st_d = S_AG_RD;
      end
      S_SRV: begin
        if (srv_q == SRV_W'(NUM_SERVERS)) begin
          srv_d = '0;
          st_d  = S_CNT;
        end else if (busy_q[srv_q]) begin
          srv_d = srv_q + 1'b1;
        end else begin
          pass_d   = '0;
          idx_d    = '0;
          bvalid_d = 1'b0;
          st_d     = S_PASS;
        end
      end
      S_PASS: begin
        if (!pl.valid) begin
          st_d = S_PICK;
        end else if (idx_q < limit) begin
          rd_en  = 1'b1;
          rd_sel = pl.q;
          st_d   = S_MUL;
        end else if (pl.stop && bvalid_q) begin
          st_d = S_PICK;
        end else begin
          pass_d = pass_q + 1'b1;
          idx_d  = '0;
        end
      end
      S_MUL: begin
        cage_d = now_q - cand_q.arr;
        bage_d = now_q - best_q.arr;
        lhs_d  = (17'(cage_d) + 17'(cand_q.svc)) * best_q.svc;
        rhs_d  = (17'(bage_d) + 17'(best_q.svc)) * cand_q.svc;
        st_d   = S_CMP;
      end
      S_CMP: begin
        if (!bvalid_q || better) begin
          bvalid_d = 1'b1;
          best_d   = cand_q;
          bq_d     = pl.q;
          bidx_d   = idx_q;
        end
        idx_d = idx_q + 1'b1;
        st_d  = S_PASS;
      end
      S_PICK: begin
        if (!bvalid_q) begin
          srv_d = srv_q + 1'b1;
          st_d  = S_SRV;
        end else if (!res_full_i) begin
          take_en          = 1'b1;
          take_sel         = bq_q;
          take_idx         = bidx_q;
          cnt_d[bq_q]      = cnt_q[bq_q] - 1'b1;
          busy_d[srv_q]    = 1'b1;
          sjob_d[srv_q]    = best_q;
          rem_d[srv_q]     = best_q.svc;
          res_push_o       = 1'b1;
          res_o.kind       = K_STARTED;
          res_o.server     = srv_q + 1'b1;
          res_o.job_ident  = best_q.id;
          res_o.promoted   = best_q.promo;
          srv_d            = srv_q + 1'b1;
          st_d             = S_SRV;
        end
      end
      S_CNT: begin
        if (srv_q == SRV_W'(NUM_SERVERS)) begin
          st_d = S_END;
        end else if (!busy_q[srv_q]) begin
          srv_d = srv_q + 1'b1;
        end else if (rem_q[srv_q] != 10'd1) begin
          rem_d[srv_q] = rem_q[srv_q] - 1'b1;
          srv_d        = srv_q + 1'b1;
        end else if (!res_full_i) begin
          rem_d[srv_q]     = '0;
          busy_d[srv_q]    = 1'b0;
          res_push_o       = 1'b1;
          res_o.kind       = K_COMPLETED;
          res_o.server     = srv_q + 1'b1;
          res_o.job_ident  = sjob_q[srv_q].id;
          res_o.event_time = done_t;
          res_o.turnaround = ta;
          res_o.waiting    = ta - 16'(sjob_q[srv_q].svc);
          res_o.promoted   = sjob_q[srv_q].promo;
          srv_d            = srv_q + 1'b1;
        end
      end
      S_END: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          now_d      = now_q + 16'd1;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      now_q    <= '0;
      srv_q    <= '0;
      pass_q   <= '0;
      idx_q    <= '0;
      bvalid_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_q[c] <= '0;
      end
      for (int s = 0; s < NUM_SERVERS; s++) begin
        busy_q[s] <= 1'b0;
        rem_q[s]  <= '0;
      end
    end else begin
      st_q     <= st_d;
      now_q    <= now_d;
      srv_q    <= srv_d;
      pass_q   <= pass_d;
      idx_q    <= idx_d;
      bvalid_q <= bvalid_d;
      cnt_q    <= cnt_d;
      busy_q   <= busy_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    sjob_q <= sjob_d;
    best_q <= best_d;
    bq_q   <= bq_d;
    bidx_q <= bidx_d;
    cage_q <= cage_d;
    bage_q <= bage_d;
    lhs_q  <= lhs_d;
    rhs_q  <= rhs_d;
    if (rd_en) begin
      cand_q <= mem_q[rd_sel][rd_idx[IW-1:0]];
    end
  end

  // class queues: append at the tail, remove anywhere by shifting the rest down
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        if (take_en && (take_sel == 2'(c)) && (k < QUEUE_DEPTH - 1) &&
            (CW'(k) >= take_idx)) begin
          mem_q[c][k] <= mem_q[c][(k < QUEUE_DEPTH - 1) ? k + 1 : k];
        end
        if (push_en && (push_sel == 2'(c)) && (cnt_q[c] == CW'(k))) begin
          mem_q[c][k] <= push_job;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/multi_queue_counter_scheduler.sv
// top level of the multi-queue job scheduler
`default_nettype none

// Three class queues (first, business, economy) of QUEUE_DEPTH jobs feed five
// non-preemptive servers. An arrival transaction gives one result. A tick
// transaction gives the started results, the completed results in server
// order and a closing tick-end result flagged last. A tick first ages the economy
// jobs (in mixed mode), then, for each idle server, runs a selection scan over
// the queued jobs (up to all 3*QUEUE_DEPTH jobs in shortest-job mode); the scan
// reads one queued job at a time through a single read port.
// Two commands and sixteen results are buffered. Configuration is written
// through a separate valid/ready port that is always ready.
module multi_queue_counter_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        command_i,
  input  wire logic [15:0]                 job_id_i,
  input  wire logic [1:0]                  grade_i,
  input  wire logic [9:0]                  service_time_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [2:0]                       kind_o,
  output logic [2:0]                       server_o,
  output logic [15:0]                      job_ident_o,
  output logic [15:0]                      event_time_o,
  output logic [15:0]                      turnaround_o,
  output logic [15:0]                      waiting_o,
  output logic                             promoted_o,
  output logic                             last_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [mqcs_pkg::CFG_AW-1:0] cfg_index_i,
  input  wire logic [mqcs_pkg::CFG_DW-1:0] cfg_data_i
);
  import mqcs_pkg::*;

  logic [1:0]  mode_q;
  logic [15:0] promote_q;
  logic        cmd_valid, cmd_pop, res_push, res_full;
  cmd_t        cmd;
  res_t        res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_MIXED;
      promote_q <= 16'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        CFG_PROMOTE: promote_q <= cfg_data_i[15:0];
        default:     mode_q    <= mode_q;
      endcase
    end
  end

  mqcs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .job_id_i       (job_id_i),
    .grade_i        (grade_i),
    .service_time_i (service_time_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop),
    .cmd_o          (cmd)
  );

  mqcs_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_q),
    .promote_after_i (promote_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .cmd_i           (cmd),
    .res_push_o      (res_push),
    .res_full_i      (res_full),
    .res_o           (res_in)
  );

  mqcs_rfifo u_rfifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .empty_o   (empty),
    .rd_en_i   (pop),
    .rd_data_o (res_out)
  );

  assign kind_o       = res_out.kind;
  assign server_o     = res_out.server;
  assign job_ident_o  = res_out.job_ident;
  assign event_time_o = res_out.event_time;
  assign turnaround_o = res_out.turnaround;
  assign waiting_o    = res_out.waiting;
  assign promoted_o   = res_out.promoted;
  assign last_o       = res_out.last;

endmodule

`default_nettype wire

>>> tb/sv/tb_multi_queue_counter_scheduler.sv
// self-checking testbench of the multi-queue scheduler: directed table, then random phases
`default_nettype none

module tb_multi_queue_counter_scheduler;
  import mqcs_pkg::*;

  localparam int QDEPTH = 16;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct {
    bit [15:0] id;
    bit [15:0] arr;
    bit [9:0]  svc;
    bit        promo;
  } job_s;

  typedef struct {
    bit        cmd;
    bit [15:0] id;
    bit [1:0]  grade;
    bit [9:0]  svc;
    bit        typed;
    kind_e     kind;
    bit [15:0] stamp;
  } row_s;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic command_i = 1'b0;
  logic [15:0] job_id_i = '0;
  logic [1:0] grade_i = '0;
  logic [9:0] service_time_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] kind_o;
  logic [2:0] server_o;
  logic [15:0] job_ident_o;
  logic [15:0] event_time_o;
  logic [15:0] turnaround_o;
  logic [15:0] waiting_o;
  logic promoted_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_AW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  multi_queue_counter_scheduler u_top (.*);

  always #2 clk_i = ~clk_i;

  // scheduler state mirrored for prediction
  mode_e     sched_mode;
  bit [15:0] promote_limit;
  bit [15:0] clock_now;
  job_s      class_q[3][QDEPTH];
  int        class_n[3];
  bit        srv_busy[NUM_SERVERS];
  bit [9:0]  srv_left[NUM_SERVERS];
  job_s      srv_job[NUM_SERVERS];

  res_t expected_events[$];
  int   mismatches = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   quiet_cycles = 0;

  function automatic bit [15:0] age_of(job_s j);
    return clock_now - j.arr;
  endfunction

  function automatic bit shorter(job_s a, job_s b);
    if (a.svc != b.svc) return a.svc < b.svc;
    return age_of(a) > age_of(b);
  endfunction

  function automatic bit higher_ratio(job_s a, job_s b);
    longint unsigned lhs, rhs;
    lhs = (longint'(age_of(a)) + a.svc) * b.svc;
    rhs = (longint'(age_of(b)) + b.svc) * a.svc;
    return lhs > rhs;
  endfunction

  function automatic job_s take_job(int q, int idx);
    job_s j;
    j = class_q[q][idx];
    for (int i = idx; i + 1 < class_n[q]; i++) class_q[q][i] = class_q[q][i+1];
    class_n[q]--;
    return j;
  endfunction

  function automatic bit enqueue_job(int q, job_s j);
    if (class_n[q] >= QDEPTH) return 1'b0;
    class_q[q][class_n[q]] = j;
    class_n[q]++;
    return 1'b1;
  endfunction

  function automatic int best_of(int q, bit by_ratio);
    int b;
    b = -1;
    for (int i = 0; i < class_n[q]; i++) begin
      if (b < 0) b = i;
      else if (by_ratio ? higher_ratio(class_q[q][i], class_q[q][b])
                        : shorter(class_q[q][i], class_q[q][b])) b = i;
    end
    return b;
  endfunction

  function automatic bit select_job(int s, output job_s j);
    int q, idx;
    q = -1;
    idx = -1;
    case (sched_mode)
      MODE_FCFS: begin
        for (int k = 0; k < 3; k++)
          if (class_n[k] != 0 && (q < 0 || age_of(class_q[k][0]) > age_of(class_q[q][0])))
            q = k;
        idx = 0;
      end
      MODE_CLASS: begin
        for (int k = 2; k >= 0; k--) if (class_n[k] != 0) q = k;
        idx = 0;
      end
      MODE_SJF: begin
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < class_n[k]; i++)
            if (q < 0 || shorter(class_q[k][i], class_q[q][idx])) begin
              q = k;
              idx = i;
            end
      end
      default: begin
        case (s)
          0: if (class_n[Q_FIRST] != 0) begin
            q = Q_FIRST;
            idx = 0;
          end
          1: begin q = Q_BUSINESS; idx = best_of(Q_BUSINESS, 1'b1); end
          2: begin q = Q_ECONOMY; idx = best_of(Q_ECONOMY, 1'b0); end
          3: begin
            q = Q_ECONOMY;
            idx = best_of(Q_ECONOMY, 1'b0);
            if (idx < 0) begin q = Q_BUSINESS; idx = best_of(Q_BUSINESS, 1'b1); end
          end
          default: begin
            q = Q_BUSINESS;
            idx = best_of(Q_BUSINESS, 1'b1);
            if (idx < 0) begin q = Q_ECONOMY; idx = best_of(Q_ECONOMY, 1'b0); end
          end
        endcase
      end
    endcase
    if (q < 0 || idx < 0) return 1'b0;
    j = take_job(q, idx);
    return 1'b1;
  endfunction

  function automatic void add_event(kind_e k, bit [2:0] s, bit [15:0] id, bit [15:0] t,
                                    bit [15:0] ta, bit [15:0] w, bit pr);
    res_t r;
    r.kind = k;
    r.server = s;
    r.job_ident = id;
    r.event_time = t;
    r.turnaround = ta;
    r.waiting = w;
    r.promoted = pr;
    r.last = 1'b0;
    expected_events = {expected_events, r};
  endfunction

  function automatic void predict_events(bit cmd, bit [15:0] id, bit [1:0] g, bit [9:0] svc);
    job_s j;
    int i;
    bit [15:0] done, ta;
    kind_e arr_kind;
    if (!cmd) begin
      j.id = id;
      j.arr = clock_now;
      j.svc = (svc == 0) ? 10'd1 : svc;
      j.promo = 1'b0;
      if (enqueue_job(g == 2'd1 ? Q_FIRST : g == 2'd2 ? Q_BUSINESS : Q_ECONOMY, j))
        arr_kind = K_ACCEPTED;
      else arr_kind = K_DROPPED;
      add_event(arr_kind, 3'd0, id, clock_now, 16'd0, 16'd0, 1'b0);
    end else begin
      if (sched_mode == MODE_MIXED) begin
        i = 0;
        while (i < class_n[Q_ECONOMY]) begin
          j = class_q[Q_ECONOMY][i];
          if (age_of(j) > promote_limit && !j.promo && class_n[Q_BUSINESS] < QDEPTH) begin
            j = take_job(Q_ECONOMY, i);
            j.promo = 1'b1;
            void'(enqueue_job(Q_BUSINESS, j));
          end else i++;
        end
      end
      for (int s = 0; s < NUM_SERVERS; s++)
        if (!srv_busy[s] && select_job(s, j)) begin
          srv_busy[s] = 1'b1;
          srv_job[s] = j;
          srv_left[s] = j.svc;
          add_event(K_STARTED, 3'(s + 1), j.id, clock_now, 16'd0, 16'd0, j.promo);
        end
      for (int s = 0; s < NUM_SERVERS; s++)
        if (srv_busy[s]) begin
          srv_left[s]--;
          if (srv_left[s] == 0) begin
            done = clock_now + 16'd1;
            ta = done - srv_job[s].arr;
            add_event(K_COMPLETED, 3'(s + 1), srv_job[s].id, done, ta,
                      ta - 16'(srv_job[s].svc), srv_job[s].promo);
            srv_busy[s] = 1'b0;
          end
        end
      add_event(K_TICK_END, 3'd0, 16'd0, clock_now, 16'd0, 16'd0, 1'b0);
      clock_now++;
    end
    expected_events[$].last = 1'b1;
  endfunction

  task automatic send_item(bit cmd, bit [15:0] id, bit [1:0] g, bit [9:0] svc,
                           bit typed = 1'b0, kind_e k = K_ACCEPTED, bit [15:0] t = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    job_id_i <= id;
    grade_i <= g;
    service_time_i <= svc;
    do @(posedge clk_i); while (full);
    predict_events(cmd, id, g, svc);
    if (typed) begin
      expected_events[$].kind = k;
      expected_events[$].event_time = t;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, bit [15:0] val);
    drain_results();
    repeat (20) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MODE) sched_mode = mode_e'(val[1:0]);
    else promote_limit = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) pop <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction kind %0d job %h", kind_o, job_ident_o);
      end else begin
        exp_r = expected_events.pop_front();
        if (kind_o != exp_r.kind || server_o != exp_r.server ||
            job_ident_o != exp_r.job_ident || event_time_o != exp_r.event_time ||
            turnaround_o != exp_r.turnaround || waiting_o != exp_r.waiting ||
            promoted_o != exp_r.promoted || last_o != exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d s%0d j%h t%0d ta%0d w%0d p%0d l%0d got k%0d s%0d j%h t%0d ta%0d w%0d p%0d l%0d",
                     exp_r.kind, exp_r.server, exp_r.job_ident, exp_r.event_time,
                     exp_r.turnaround, exp_r.waiting, exp_r.promoted, exp_r.last,
                     kind_o, server_o, job_ident_o, event_time_o, turnaround_o,
                     waiting_o, promoted_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_queue_counter_scheduler test failed");
      $finish;
    end
  end

  row_s rows[] = '{
    '{1'b0, 16'h0000, 2'd1, 10'd1023, 1'b1, K_ACCEPTED, 16'd0},
    '{1'b0, 16'hFFFF, 2'd2, 10'd0,    1'b1, K_ACCEPTED, 16'd0},
    '{1'b0, 16'h1234, 2'd3, 10'd1,    1'b1, K_ACCEPTED, 16'd0},
    '{1'b0, 16'h5555, 2'd0, 10'd2,    1'b1, K_ACCEPTED, 16'd0},
    '{1'b0, 16'hAAAA, 2'd3, 10'd2,    1'b1, K_ACCEPTED, 16'd0},
    '{1'b0, 16'h0F0F, 2'd3, 10'd3,    1'b1, K_ACCEPTED, 16'd0},
    '{1'b0, 16'h00FF, 2'd2, 10'd3,    1'b1, K_ACCEPTED, 16'd0},
    '{1'b1, 16'hFFFF, 2'd3, 10'h3FF,  1'b0, K_TICK_END, 16'd0},
    '{1'b1, 16'h0000, 2'd0, 10'd0,    1'b0, K_TICK_END, 16'd0},
    '{1'b0, 16'h7777, 2'd2, 10'd5,    1'b1, K_ACCEPTED, 16'd2},
    '{1'b0, 16'h8888, 2'd2, 10'd1,    1'b1, K_ACCEPTED, 16'd2},
    '{1'b0, 16'h9999, 2'd3, 10'd512,  1'b1, K_ACCEPTED, 16'd2},
    '{1'b1, 16'h0000, 2'd0, 10'd0,    1'b0, K_TICK_END, 16'd0},
    '{1'b1, 16'h0000, 2'd0, 10'd0,    1'b0, K_TICK_END, 16'd0},
    '{1'b0, 16'h3C3C, 2'd1, 10'd4,    1'b1, K_ACCEPTED, 16'd4},
    '{1'b1, 16'h0000, 2'd0, 10'd0,    1'b0, K_TICK_END, 16'd0},
    '{1'b1, 16'h0000, 2'd0, 10'd0,    1'b0, K_TICK_END, 16'd0},
    '{1'b1, 16'h0000, 2'd0, 10'd0,    1'b0, K_TICK_END, 16'd0}
  };

  task automatic random_item(ref int sent);
    int burst;
    bit [1:0] g;
    if ($urandom_range(99) < 8) begin
      // burst into one class to overflow it
      burst = $urandom_range(10, 20);
      g = 2'($urandom_range(0, 3));
      repeat (burst) send_item(1'b0, 16'($urandom), g, 10'($urandom_range(1, 6)));
      sent += burst;
    end else if ($urandom_range(99) < 45) begin
      send_item(1'b1, 16'($urandom), 2'($urandom), 10'($urandom));
      sent++;
    end else begin
      send_item(1'b0, 16'($urandom), 2'($urandom_range(0, 3)),
                ($urandom_range(99) < 4) ? 10'($urandom) :
                ($urandom_range(99) < 10) ? 10'd0 : 10'($urandom_range(1, 6)));
      sent++;
    end
  endtask

  initial begin
    int sent;
    bit [1:0] modes[6];
    bit [15:0] limits[6];
    modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3};
    limits = '{16'd65535, 16'd0, 16'd9, 16'd0, 16'd65535, 16'd3};
    sched_mode = MODE_MIXED;
    promote_limit = 16'd20;
    clock_now = '0;
    class_n = '{0, 0, 0};
    srv_busy = '{default: 1'b0};
    srv_left = '{default: '0};
    snd_idle = 28;
    rcv_idle = 77;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].id, rows[i].grade, rows[i].svc,
                rows[i].typed, rows[i].kind, rows[i].stamp);
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_MODE, 16'(modes[p]));
      write_reg(CFG_PROMOTE, limits[p]);
      snd_idle = (p < 2) ? 28 : (p < 4) ? 77 : 0;
      rcv_idle = (p < 2) ? 77 : (p < 4) ? 28 : 0;
      sent = 0;
      while (sent < 72) begin
        random_item(sent);
        if (p == 1 && sent >= 30 && sent < 32) drain_results();
      end
    end
    drain_results();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0)
      $display("multi_queue_counter_scheduler test passed");
    else
      $display("multi_queue_counter_scheduler test failed");
    $finish;
  end

endmodule

`default_nettype wire
